FILE: hw/rtl/least_used_channel_selector_macros.svh
// Assertion macros shared by the least used channel selector.
`ifndef LEAST_USED_CHANNEL_SELECTOR_MACROS_SVH
`define LEAST_USED_CHANNEL_SELECTOR_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define LUCS_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lucs: same-cycle check failed");

// Next-cycle implication, checked only while out of reset.
`define LUCS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lucs: next-cycle check failed");

`endif

FILE: hw/rtl/lucs_pkg.sv
// Types, constants and helpers for the least used channel selector.
package lucs_pkg;

	localparam int NUM_CHANNELS = 4;
	localparam int POWER_FIELDS = 4;
	localparam int CH_W = 3;
	localparam int PWR_W = 16;
	localparam int CNT_W = 32;
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef logic [CH_W-1:0] chan_t;
	typedef logic [PWR_W-1:0] power_t;
	typedef logic [CNT_W-1:0] count_t;

	typedef struct packed {
		logic [2:0]  su_channel;
		logic [15:0] power_ch1;
		logic [15:0] power_ch2;
		logic [15:0] power_ch3;
		logic [15:0] power_ch4;
	} lucs_in_t;

	typedef struct packed {
		logic [2:0] target_channel;
		logic [2:0] primary_channel;
	} lucs_out_t;

	// Classified beat handed from the front to the back.
	typedef struct packed {
		chan_t cur;
		chan_t pu;
		logic  move;
	} lucs_cls_t;

	typedef struct packed {
		logic full;
		logic empty;
	} lucs_qstat_t;

	typedef struct packed {
		logic   take;
		logic   found;
		count_t total;
	} lucs_bstat_t;

	// Channels past the four reported fields read as zero power.
	function automatic power_t power_of(input lucs_in_t d, input int idx);
		power_t p;
		case (idx)
			0: p = d.power_ch1;
			1: p = d.power_ch2;
			2: p = d.power_ch3;
			3: p = d.power_ch4;
			default: p = '0;
		endcase
		return p;
	endfunction

	function automatic count_t sat_inc(input count_t v);
		return (v == CNT_MAX) ? v : v + count_t'(1);
	endfunction

endpackage

FILE: hw/rtl/lucs_front.sv
// Front end: finds the primary user channel of each sensing beat.
module lucs_front import lucs_pkg::*; (
	input  lucs_in_t  sense,
	output lucs_cls_t cls
);

	power_t pwr [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] elig;
	logic [NUM_CHANNELS-1:0] win;
	logic cur_valid;
	logic cur_pos;
	chan_t pu_other;
	chan_t pu;

	assign cur_valid = (sense.su_channel != '0)
		&& ({1'b0, sense.su_channel} <= (CH_W+1)'(NUM_CHANNELS));

	always_comb begin
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			pwr[i] = power_of(sense, i);
			elig[i] = (pwr[i] != '0) && !(cur_valid && (chan_t'(i + 1) == sense.su_channel));
		end
	end

	// Each channel compares against all others at once; the lower index wins a tie.
	always_comb begin
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			win[i] = elig[i];
			for (int j = 0; j < NUM_CHANNELS; j++) begin
				if (j < i && elig[j] && !(pwr[i] > pwr[j])) begin
					win[i] = 1'b0;
				end else if (j > i && elig[j] && (pwr[i] < pwr[j])) begin
					win[i] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		pu_other = '0;
		cur_pos = 1'b0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (win[i]) begin
				pu_other = pu_other | chan_t'(i + 1);
			end
			if (chan_t'(i + 1) == sense.su_channel && pwr[i] != '0) begin
				cur_pos = 1'b1;
			end
		end
	end

	assign pu = (pu_other == '0 && cur_valid && cur_pos) ? sense.su_channel : pu_other;

	assign cls.cur = sense.su_channel;
	assign cls.pu = pu;
	assign cls.move = (pu != '0) && (pu == sense.su_channel);

endmodule

FILE: hw/rtl/lucs_queue.sv
// Short queue of classified beats between the front and the back.
module lucs_queue import lucs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  lucs_cls_t   push_data,
	output logic        pop_valid,
	input  logic        pop_ready,
	output lucs_cls_t   pop_data,
	output lucs_qstat_t stat
);

	lucs_cls_t mem [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = (count_q != Q_CNT_W'(Q_DEPTH));
	assign pop_valid = (count_q != '0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = mem[rd_ptr_q];
	assign stat.full = !push_ready;
	assign stat.empty = !pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/lucs_back.sv
// Back end: occupancy counters, least used channel choice and result register.
module lucs_back import lucs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  lucs_cls_t   q_data,
	output logic        choice_valid,
	input  logic        choice_ready,
	output lucs_out_t   choice,
	output lucs_bstat_t stat
);

	count_t cnt_q [NUM_CHANNELS];
	count_t total_q;
	count_t tot_new;
	logic valid_q;
	lucs_out_t choice_q;
	logic take;
	logic found;
	logic [NUM_CHANNELS-1:0] elig;
	logic [NUM_CHANNELS-1:0] win;
	chan_t pick;
	chan_t next;

	assign take = q_valid && (!valid_q || choice_ready);
	assign q_ready = take;
	assign found = (q_data.pu != '0);
	assign tot_new = sat_inc(total_q);

	// The primary channel is left out of the search, so its pending bump does not matter.
	always_comb begin
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			elig[i] = (chan_t'(i + 1) != q_data.pu) && (cnt_q[i] < tot_new);
		end
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			win[i] = elig[i];
			for (int j = 0; j < NUM_CHANNELS; j++) begin
				if (j < i && elig[j] && !(cnt_q[i] < cnt_q[j])) begin
					win[i] = 1'b0;
				end else if (j > i && elig[j] && (cnt_q[j] < cnt_q[i])) begin
					win[i] = 1'b0;
				end
			end
		end
		pick = '0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (win[i]) begin
				pick = pick | chan_t'(i + 1);
			end
		end
	end

	// When the beat must move and no candidate remains, the choice falls to channel one.
	assign next = q_data.move ? ((win != '0) ? pick : chan_t'(1)) : q_data.cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				cnt_q[i] <= '0;
			end
			total_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (take && found) begin
				total_q <= tot_new;
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					if (chan_t'(i + 1) == q_data.pu) begin
						cnt_q[i] <= sat_inc(cnt_q[i]);
					end
				end
			end
			if (take) begin
				valid_q <= 1'b1;
			end else if (choice_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			choice_q.target_channel <= next;
			choice_q.primary_channel <= q_data.pu;
		end
	end

	assign choice_valid = valid_q;
	assign choice = choice_q;
	assign stat.take = take;
	assign stat.found = found;
	assign stat.total = total_q;

endmodule

FILE: hw/rtl/least_used_channel_selector.sv
// Top level of the least used channel selector.
//
// Usage: one sensing beat on the sense channel (valid/ready) carries the
// current channel and four power readings. Each beat yields exactly one
// beat on the choice channel with the next channel and the detected
// primary user channel, in order.
// Path: an accepted beat is written to the two-entry queue, then taken by
// the back end into the result register and shown on the choice channel;
// the back end takes no beat while an unread result is held.
// Throughput: one beat per cycle while the receiver accepts results; the back
// end reads and updates occupancy counters together; no beat waits on them.
// Reset empties the queue and clears the result valid flag, all occupancy
// counters and the detection total.
// When the receiver stalls, the result register holds, the queue fills,
// and sense_ready drops once both queue entries are occupied.
`include "least_used_channel_selector_macros.svh"

module least_used_channel_selector import lucs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      sense_valid,
	output logic      sense_ready,
	input  lucs_in_t  sense,
	output logic      choice_valid,
	input  logic      choice_ready,
	output lucs_out_t choice
);

	lucs_cls_t cls;
	lucs_cls_t q_data;
	logic q_valid;
	logic q_ready;
	lucs_qstat_t qstat;
	lucs_bstat_t bstat;

	lucs_front u_front (
		.sense (sense),
		.cls   (cls)
	);

	lucs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (sense_valid),
		.push_ready (sense_ready),
		.push_data  (cls),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data),
		.stat       (qstat)
	);

	lucs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_data       (q_data),
		.choice_valid (choice_valid),
		.choice_ready (choice_ready),
		.choice       (choice),
		.stat         (bstat)
	);

	`LUCS_ASSERT_NOW(a_queue_state, 1'b1, !(qstat.full && qstat.empty))
	`LUCS_ASSERT_NEXT(a_take_loads_result, bstat.take, choice_valid)
	`LUCS_ASSERT_NEXT(a_total_nonzero, bstat.take && bstat.found, bstat.total != '0)
	`LUCS_ASSERT_NEXT(a_total_holds, !bstat.take, $stable(bstat.total))

endmodule
